>>> sv/icmperm_pkg.sv
// Package for the ICMP echo reply matcher.
// Holds the verdict codes, frame layout constants and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmperm_pkg;

  localparam int unsigned OffW       = 7;
  localparam int unsigned LenW       = 8;
  localparam int unsigned IhlW       = 4;
  localparam int unsigned HdrBytesW  = 6;
  localparam int unsigned RegW       = 16;

  localparam logic [OffW-1:0] EthHdrBytes   = 7'd14;
  localparam logic [OffW-1:0] EthTypeHiOff  = 7'd12;
  localparam logic [OffW-1:0] EthTypeLoOff  = 7'd13;
  localparam logic [OffW-1:0] ProtoOff      = 7'd23;
  localparam logic [OffW-1:0] OffsetMax     = 7'd127;
  localparam logic [LenW-1:0] MinFrameBytes = 8'd42;

  localparam logic [15:0] EtherTypeIpv4     = 16'h0800;
  localparam logic [7:0]  ProtoIcmp         = 8'd1;
  localparam logic [7:0]  IcmpTypeEchoReply = 8'd0;

  localparam logic [RegW-1:0] ExpectedIdReset  = 16'h4A50;
  localparam logic [RegW-1:0] ExpectedSeqReset = 16'h0000;

  typedef enum logic [0:0] {
    REG_EXPECTED_ID  = 1'b0,
    REG_EXPECTED_SEQ = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_MATCH     = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_NOT_IPV4  = 3'd2,
    VERDICT_NOT_ICMP  = 3'd3,
    VERDICT_NOT_REPLY = 3'd4,
    VERDICT_WRONG_ID  = 3'd5,
    VERDICT_WRONG_SEQ = 3'd6
  } verdict_e;

  typedef struct packed {
    logic                 valid;
    verdict_e             verdict;
    logic [HdrBytesW-1:0] ip_header_bytes;
  } result_t;

endpackage

`default_nettype wire

>>> sv/icmperm_frame_chk.sv
// Per-frame header checker of the ICMP echo reply matcher.
// Tracks byte position and check flags; forms the verdict on the last beat.
// Depends on icmperm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmperm_frame_chk
  import icmperm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            beat_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_byte_i,
  input  wire logic [RegW-1:0] expected_id_i,
  input  wire logic [RegW-1:0] expected_seq_i,
  output result_t              result_o
);

  logic [OffW-1:0] off_q, off_d;
  logic [IhlW-1:0] ihl_q, ihl_d;
  logic            eth_ok_q, eth_ok_d;
  logic            proto_ok_q, proto_ok_d;
  logic            type_ok_q, type_ok_d;
  logic            id_ok_q, id_ok_d;
  logic            seq_ok_q, seq_ok_d;
  logic [7:0]      hold_q, hold_d;

  logic [OffW-1:0] base;
  logic [LenW-1:0] len;
  logic [LenW-1:0] need;
  verdict_e        verdict;

  always_comb begin
    ihl_d      = ihl_q;
    eth_ok_d   = eth_ok_q;
    proto_ok_d = proto_ok_q;
    type_ok_d  = type_ok_q;
    id_ok_d    = id_ok_q;
    seq_ok_d   = seq_ok_q;
    hold_d     = hold_q;

    if (off_q == EthHdrBytes) begin
      ihl_d = data_byte_i[IhlW-1:0];
    end
    base = EthHdrBytes + {1'b0, ihl_d, 2'b00};

    if (off_q == EthTypeHiOff) begin
      hold_d = data_byte_i;
    end else if (off_q == EthTypeLoOff) begin
      eth_ok_d = ({hold_q, data_byte_i} == EtherTypeIpv4);
    end
    if (off_q == ProtoOff) begin
      proto_ok_d = (data_byte_i == ProtoIcmp);
    end

    if (off_q == base) begin
      type_ok_d = (data_byte_i == IcmpTypeEchoReply);
    end else if (off_q == base + 7'd4 || off_q == base + 7'd6) begin
      hold_d = data_byte_i;
    end else if (off_q == base + 7'd5) begin
      id_ok_d = ({hold_q, data_byte_i} == expected_id_i);
    end else if (off_q == base + 7'd7) begin
      seq_ok_d = ({hold_q, data_byte_i} == expected_seq_i);
    end

    off_d = (off_q < OffsetMax) ? off_q + 7'd1 : off_q;

    len  = {1'b0, off_q} + 8'd1;
    need = {1'b0, base} + 8'd8;
    priority if (len < MinFrameBytes) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (!eth_ok_d) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (!proto_ok_d) begin
      verdict = VERDICT_NOT_ICMP;
    end else if (len < need) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (!type_ok_d) begin
      verdict = VERDICT_NOT_REPLY;
    end else if (!id_ok_d) begin
      verdict = VERDICT_WRONG_ID;
    end else if (!seq_ok_d) begin
      verdict = VERDICT_WRONG_SEQ;
    end else begin
      verdict = VERDICT_MATCH;
    end

    result_o.valid           = beat_i && last_byte_i;
    result_o.verdict         = verdict;
    result_o.ip_header_bytes = {ihl_d, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      ihl_q      <= '0;
      eth_ok_q   <= 1'b1;
      proto_ok_q <= 1'b1;
      type_ok_q  <= 1'b1;
      id_ok_q    <= 1'b1;
      seq_ok_q   <= 1'b1;
      hold_q     <= '0;
    end else if (beat_i) begin
      if (last_byte_i) begin
        off_q      <= '0;
        ihl_q      <= '0;
        eth_ok_q   <= 1'b1;
        proto_ok_q <= 1'b1;
        type_ok_q  <= 1'b1;
        id_ok_q    <= 1'b1;
        seq_ok_q   <= 1'b1;
        hold_q     <= '0;
      end else begin
        off_q      <= off_d;
        ihl_q      <= ihl_d;
        eth_ok_q   <= eth_ok_d;
        proto_ok_q <= proto_ok_d;
        type_ok_q  <= type_ok_d;
        id_ok_q    <= id_ok_d;
        seq_ok_q   <= seq_ok_d;
        hold_q     <= hold_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/icmp_echo_reply_matcher.sv
// ICMP echo reply matcher: one frame byte per beat, one verdict per frame.
// The verdict is registered and appears in the cycle after the last byte's beat.
// Throughput: one byte per cycle while the verdict output drains; any byte is
// held off while a verdict waits on a stalled output.
// Reset clears frame state and loads expected_id 0x4A50 and expected_seq 0.
// Depends on icmperm_pkg and icmperm_frame_chk.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_matcher
  import icmperm_pkg::*;
#(
  parameter int unsigned CfgIdxW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // data_byte
  input  wire logic               s_axis_tlast,   // last_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // verdict[2:0], ip_header_bytes[8:3]
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [RegW-1:0]    cfg_data_i
);

  logic [RegW-1:0]      exp_id_q;
  logic [RegW-1:0]      exp_seq_q;
  logic                 out_valid_q;
  verdict_e             verdict_q;
  logic [HdrBytesW-1:0] hdr_bytes_q;
  logic                 beat;
  result_t              result;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q  <= ExpectedIdReset;
      exp_seq_q <= ExpectedSeqReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxW'(REG_EXPECTED_ID)) begin
        exp_id_q <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxW'(REG_EXPECTED_SEQ)) begin
        exp_seq_q <= cfg_data_i;
      end
    end
  end

  icmperm_frame_chk u_frame_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .data_byte_i    (s_axis_tdata),
    .last_byte_i    (s_axis_tlast),
    .expected_id_i  (exp_id_q),
    .expected_seq_i (exp_seq_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && result.valid) begin
      verdict_q   <= result.verdict;
      hdr_bytes_q <= result.ip_header_bytes;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, hdr_bytes_q, verdict_q};

  a_verdict_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7))
    else $error("verdict code out of range");

  a_hdr_bytes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] == 2'b00))
    else $error("header length not a multiple of four");

  a_verdict_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tlast))
    else $error("verdict without a last beat");

  a_upper_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
    else $error("padding bits set");

endmodule

`default_nettype wire
